// ===== hdl/hbsd_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the heap builder.
package hbsd_pkg;

  localparam int KEY_W     = 32;
  localparam int DEPTH_DEF = 64;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIGNED = CFG_IDX_W'(1);

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses
  localparam step_t S_LOAD       = 4'd0;
  localparam step_t S_INIT       = 4'd1;
  localparam step_t S_RD_ROOT    = 4'd2;
  localparam step_t S_RD_LEFT    = 4'd3;
  localparam step_t S_RD_RIGHT   = 4'd4;
  localparam step_t S_CMP_RIGHT  = 4'd5;
  localparam step_t S_SWAP_ROOT  = 4'd6;
  localparam step_t S_SWAP_CHILD = 4'd7;
  localparam step_t S_NEXT_NODE  = 4'd8;
  localparam step_t S_EMIT_RD    = 4'd9;
  localparam step_t S_EMIT_OUT   = 4'd10;
  localparam step_t S_EMIT_NXT   = 4'd11;
  localparam step_t S_DONE       = 4'd12;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_RD_ROOT,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_CMP_RIGHT,
    OP_SWAP_ROOT,
    OP_SWAP_CHILD,
    OP_NEXT_NODE,
    OP_EMIT_RD,
    OP_EMIT_OUT,
    OP_DONE
  } op_t;

  // Jump conditions; when false the step counter advances by one
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_NOT_LAST,
    C_NO_SWAP,
    C_NODE_NZ,
    C_OUT_BUSY,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
  } uword_t;

  // Control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_LOAD:       w = '{OP_LOAD,       C_NOT_LAST, S_LOAD};
      S_INIT:       w = '{OP_INIT,       C_NEXT,     S_LOAD};
      S_RD_ROOT:    w = '{OP_RD_ROOT,    C_NEXT,     S_LOAD};
      S_RD_LEFT:    w = '{OP_RD_LEFT,    C_NEXT,     S_LOAD};
      S_RD_RIGHT:   w = '{OP_RD_RIGHT,   C_NEXT,     S_LOAD};
      S_CMP_RIGHT:  w = '{OP_CMP_RIGHT,  C_NEXT,     S_LOAD};
      S_SWAP_ROOT:  w = '{OP_SWAP_ROOT,  C_NO_SWAP,  S_NEXT_NODE};
      S_SWAP_CHILD: w = '{OP_SWAP_CHILD, C_JUMP,     S_RD_ROOT};
      S_NEXT_NODE:  w = '{OP_NEXT_NODE,  C_NODE_NZ,  S_RD_ROOT};
      S_EMIT_RD:    w = '{OP_EMIT_RD,    C_NEXT,     S_LOAD};
      S_EMIT_OUT:   w = '{OP_EMIT_OUT,   C_OUT_BUSY, S_EMIT_OUT};
      S_EMIT_NXT:   w = '{OP_NOP,        C_MORE,     S_EMIT_RD};
      S_DONE:       w = '{OP_DONE,       C_JUMP,     S_LOAD};
      default:      w = '{OP_NOP,        C_JUMP,     S_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/heap_build_sift_down.sv =====
// Heap builder: loads a key set, heapifies it in place, streams the heap out.
//
//  channel | direction | handshake          | words
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall   | in_key, in_last
//  out_    | output    | out_valid/out_stall | out_key, out_last, out_overflow
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load accepts one key per cycle. The build runs from a microprogram over a
// key store with one write and one registered read port; each node's sift
// reads the root and both children, then swaps the winner down; a set needs
// fewer swaps than it has keys. Emission reads each word and loads it into
// the output register when that is free. Input is stalled from the last key
// until emission ends; the output register holds its word under stall.
// Reset (rst_n, synchronous) clears count, flags, config and the step counter.
module heap_build_sift_down #(
  parameter int DEPTH = hbsd_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hbsd_pkg::KEY_W-1:0]     in_key,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hbsd_pkg::KEY_W-1:0]     out_key,
  output logic                           out_last,
  output logic                           out_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import hbsd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  // Key store
  logic [KEY_W-1:0] key_store_r [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  // Sequencer and datapath registers
  step_t            upc_r, upc_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             ord_r, ord_nxt;
  logic             sgn_r, sgn_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [AW-1:0]    best_r, best_nxt;
  logic [KEY_W-1:0] rkey_r, rkey_nxt;
  logic [KEY_W-1:0] bkey_r, bkey_nxt;
  logic [CW-1:0]    eidx_r, eidx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic             olast_r, olast_nxt;
  logic             oovf_r, oovf_nxt;

  uword_t           uw;
  logic             in_acc;
  logic             out_busy;
  logic             take;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [IW-1:0]    lft, rgt, n_ext;
  logic             lft_ok, rgt_ok;

  // b beats a in the heap order
  function automatic logic loses(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
                                 logic ord, logic sgn);
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] y;
    x = a;
    y = b;
    x[KEY_W-1] = a[KEY_W-1] ^ sgn;
    y[KEY_W-1] = b[KEY_W-1] ^ sgn;
    return ord ? (x < y) : (x > y);
  endfunction

  assign uw       = ucode(upc_r);
  assign in_stall = (upc_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // Child indexes
  assign lft    = IW'({cur_r, 1'b1});
  assign rgt    = IW'({cur_r, 1'b0}) + IW'(2);
  assign n_ext  = IW'(cnt_r);
  assign lft_ok = lft < n_ext;
  assign rgt_ok = rgt < n_ext;

  // Datapath driven by the control word
  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    rkey_nxt      = rkey_r;
    bkey_nxt      = bkey_r;
    eidx_nxt      = eidx_r;
    out_valid_nxt = out_valid_r && out_stall;
    okey_nxt      = okey_r;
    olast_nxt     = olast_r;
    oovf_nxt      = oovf_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = bkey_r;
    rd_en         = 1'b0;
    rd_addr       = cur_r;
    case (uw.op)
      OP_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(DEPTH)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[AW-1:0];
            wr_data = in_key;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      OP_INIT: begin
        node_nxt = AW'((cnt_r - CW'(1)) >> 1);
        cur_nxt  = AW'((cnt_r - CW'(1)) >> 1);
      end
      OP_RD_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      OP_RD_LEFT: begin
        rkey_nxt = rd_data_r;
        bkey_nxt = rd_data_r;
        best_nxt = cur_r;
        rd_en    = 1'b1;
        rd_addr  = lft[AW-1:0];
      end
      OP_RD_RIGHT: begin
        if (lft_ok && loses(bkey_r, rd_data_r, ord_r, sgn_r)) begin
          best_nxt = lft[AW-1:0];
          bkey_nxt = rd_data_r;
        end
        rd_en   = 1'b1;
        rd_addr = rgt[AW-1:0];
      end
      OP_CMP_RIGHT: begin
        if (rgt_ok && loses(bkey_r, rd_data_r, ord_r, sgn_r)) begin
          best_nxt = rgt[AW-1:0];
          bkey_nxt = rd_data_r;
        end
      end
      OP_SWAP_ROOT: begin
        // winning child moves up
        if (best_r != cur_r) begin
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = bkey_r;
        end
      end
      OP_SWAP_CHILD: begin
        wr_en   = 1'b1;
        wr_addr = best_r;
        wr_data = rkey_r;
        cur_nxt = best_r;
      end
      OP_NEXT_NODE: begin
        eidx_nxt = '0;
        if (node_r != '0) begin
          node_nxt = node_r - AW'(1);
          cur_nxt  = node_r - AW'(1);
        end
      end
      OP_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = eidx_r[AW-1:0];
      end
      OP_EMIT_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          okey_nxt      = rd_data_r;
          olast_nxt     = (eidx_r + CW'(1)) == cnt_r;
          oovf_nxt      = drop_r;
          eidx_nxt      = eidx_r + CW'(1);
        end
      end
      OP_DONE: begin
        cnt_nxt  = '0;
        drop_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Step counter: conditional jump or advance
  always_comb begin
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_JUMP:     take = 1'b1;
      C_NOT_LAST: take = !(in_acc && in_last);
      C_NO_SWAP:  take = (best_r == cur_r);
      C_NODE_NZ:  take = (node_r != '0);
      C_OUT_BUSY: take = out_busy;
      C_MORE:     take = (eidx_r != cnt_r);
      default:    take = 1'b0;
    endcase
    upc_nxt = take ? uw.tgt : upc_r + step_t'(1);
  end

  // Configuration writes
  always_comb begin
    ord_nxt = ord_r;
    sgn_nxt = sgn_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_HEAP_ORDER: ord_nxt = cfg_data;
        REG_KEY_SIGNED: sgn_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Key store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= key_store_r[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      ord_r       <= 1'b0;
      sgn_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      ord_r       <= ord_nxt;
      sgn_r       <= sgn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    cur_r   <= cur_nxt;
    best_r  <= best_nxt;
    rkey_r  <= rkey_nxt;
    bkey_r  <= bkey_nxt;
    eidx_r  <= eidx_nxt;
    okey_r  <= okey_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_key      = okey_r;
  assign out_last     = olast_r;
  assign out_overflow = oovf_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above store depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> cnt_r == CW'(DEPTH))
    else $error("drop flag set while store not full");

  a_swap_real: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == S_SWAP_CHILD |-> best_r != cur_r)
    else $error("child swap without a winning child");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc_r) == S_EMIT_OUT)
    else $error("output word loaded outside emission step");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r == S_DONE |=> cnt_r == '0 && !drop_r && upc_r == S_LOAD)
    else $error("set not cleared after emission");

endmodule
